// ----- hdl/mmss_pkg.sv -----
package mmss_pkg;

  localparam int unsigned DeltaW   = 14;
  localparam int unsigned TotalW   = 13;
  localparam int unsigned MinW     = 7;
  localparam int unsigned SecW     = 6;
  localparam int unsigned SegW     = 8;
  localparam int unsigned DigitW   = 4;

  localparam logic [TotalW-1:0] MaxTotal   = 13'd5999;
  localparam logic [TotalW-1:0] SecsPerMin = 13'd60;
  localparam logic [SegW-1:0]   ColonMask  = 8'h7F;
  localparam logic [SegW-1:0]   SegBlank   = 8'hFF;

  // t / 60 == (t * 8739) >> 19 for t <= 5999
  localparam int unsigned       DivMinProdW = 27;
  localparam logic [DivMinProdW-1:0] DivMinMul = 27'd8739;
  localparam int unsigned       DivMinShift = 19;

  // v / 10 == (v * 205) >> 11 for v <= 99
  localparam int unsigned       DivTenProdW = 15;
  localparam logic [DivTenProdW-1:0] DivTenMul = 15'd205;
  localparam int unsigned       DivTenShift = 11;

  localparam logic [SegW-1:0] DigitSeg [10] = '{
    8'hC0, 8'hF9, 8'hA4, 8'hB0, 8'h99,
    8'h92, 8'h82, 8'hF8, 8'h80, 8'h90
  };

  function automatic logic [SegW-1:0] seg_of(input logic [DigitW-1:0] digit);
    logic [SegW-1:0] seg;
    if (digit > 4'd9) begin
      seg = SegBlank;
    end else begin
      seg = DigitSeg[digit];
    end
    return seg;
  endfunction

endpackage

// ----- hdl/mmss_seg_pair.sv -----
module mmss_seg_pair
  import mmss_pkg::*;
(
  input  logic [MinW-1:0] val_i,
  output logic [SegW-1:0] seg_tens_o,
  output logic [SegW-1:0] seg_ones_o
);

  logic [DivTenProdW-1:0] prod;
  logic [DigitW-1:0]      tens;
  logic [MinW-1:0]        tens_x10;
  logic [MinW-1:0]        ones_full;
  logic [DigitW-1:0]      ones;

  always_comb begin
    prod      = {{(DivTenProdW-MinW){1'b0}}, val_i} * DivTenMul;
    tens      = prod[DivTenShift +: DigitW];
    tens_x10  = {tens, 3'b000} + {2'b00, tens, 1'b0};
    ones_full = val_i - tens_x10;
    ones      = ones_full[DigitW-1:0];
  end

  assign seg_tens_o = seg_of(tens);
  assign seg_ones_o = seg_of(ones);

endmodule

// ----- hdl/mmss_timer_seven_segment_top.sv -----
// Minutes:seconds timer with seven-segment readout. Each request on the slave
// stream adds its signed delta (seconds) to the held time, clamped to 00:00 at
// the bottom and 99:59 at the top, and produces one result: minutes, seconds,
// four active-low segment codes (colon lit on the minutes-ones digit) and a
// flag set at 00:00. One request per cycle is accepted unless the output stalls;
// a total moves from total_q to min_q/sec_q and on to the output registers. The
// rate is set by the total-seconds register, updated by one add and clamp per request.
module mmss_timer_seven_segment_top
  import mmss_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [13:0] delta_seconds, [15:14] zero
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [6:0] minutes_now, [12:7] seconds_now, [20:13] seg_minutes_tens,
  // [28:21] seg_minutes_ones, [36:29] seg_seconds_tens,
  // [44:37] seg_seconds_ones, [45] time_is_zero, [47:46] zero
  output logic [47:0] m_axis_tdata
);

  logic s_acc;
  logic a_load, b_load, o_load;

  logic              a_vld_q;
  logic [TotalW-1:0] total_q, total_d;

  logic              b_vld_q;
  logic [MinW-1:0]   min_q, min_d;
  logic [SecW-1:0]   sec_q, sec_d;
  logic              zero_q;

  logic              o_vld_q;
  logic [MinW-1:0]   o_min_q;
  logic [SecW-1:0]   o_sec_q;
  logic [SegW-1:0]   o_smt_q, o_smo_q, o_sst_q, o_sso_q;
  logic              o_zero_q;

  logic [SegW-1:0]   smt, smo, sst, sso;

  assign o_load        = !o_vld_q || m_axis_tready;
  assign b_load        = !b_vld_q || o_load;
  assign a_load        = !a_vld_q || b_load;
  assign s_axis_tready = a_load;
  assign s_acc         = s_axis_tvalid && s_axis_tready;

  // add and clamp into the running total
  logic signed [TotalW+1:0] sum;
  always_comb begin
    sum = $signed({2'b00, total_q})
        + $signed({s_axis_tdata[DeltaW-1], s_axis_tdata[DeltaW-1:0]});
    if (sum < 0) begin
      total_d = '0;
    end else if (sum > $signed({2'b00, MaxTotal})) begin
      total_d = MaxTotal;
    end else begin
      total_d = sum[TotalW-1:0];
    end
  end

  // split total into minutes and seconds
  logic [DivMinProdW-1:0] min_prod;
  logic [TotalW-1:0]      min_x60;
  logic [TotalW-1:0]      sec_full;
  always_comb begin
    min_prod = {{(DivMinProdW-TotalW){1'b0}}, total_q} * DivMinMul;
    min_d    = min_prod[DivMinShift +: MinW];
    min_x60  = {{(TotalW-MinW){1'b0}}, min_d} * SecsPerMin;
    sec_full = total_q - min_x60;
    sec_d    = sec_full[SecW-1:0];
  end

  mmss_seg_pair u_min_seg (
    .val_i      (min_q),
    .seg_tens_o (smt),
    .seg_ones_o (smo)
  );

  mmss_seg_pair u_sec_seg (
    .val_i      ({1'b0, sec_q}),
    .seg_tens_o (sst),
    .seg_ones_o (sso)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      total_q <= '0;
      b_vld_q <= 1'b0;
      o_vld_q <= 1'b0;
    end else begin
      if (a_load) begin
        a_vld_q <= s_acc;
      end
      if (s_acc) begin
        total_q <= total_d;
      end
      if (b_load) begin
        b_vld_q <= a_vld_q;
      end
      if (o_load) begin
        o_vld_q <= b_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_load && a_vld_q) begin
      min_q  <= min_d;
      sec_q  <= sec_d;
      zero_q <= (total_q == '0);
    end
    if (o_load && b_vld_q) begin
      o_min_q  <= min_q;
      o_sec_q  <= sec_q;
      o_smt_q  <= smt;
      o_smo_q  <= smo & ColonMask;
      o_sst_q  <= sst;
      o_sso_q  <= sso;
      o_zero_q <= zero_q;
    end
  end

  assign m_axis_tvalid = o_vld_q;
  assign m_axis_tdata  = {2'b00, o_zero_q, o_sso_q, o_sst_q, o_smo_q, o_smt_q,
                          o_sec_q, o_min_q};

  a_total_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q <= MaxTotal)
    else $error("running total above 99:59");

  a_sec_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    b_vld_q |-> (sec_q < 6'd60 && min_q <= 7'd99))
    else $error("minutes/seconds split out of range");

  a_zero_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    o_vld_q |-> (o_zero_q == (o_min_q == '0 && o_sec_q == '0)))
    else $error("zero flag disagrees with time");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc |-> (!a_vld_q || b_load))
    else $error("request accepted over a held total");

endmodule
